/* rtl/rlee_pkg.sv */
package rlee_pkg;

  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned WEIGHT_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF   = 2'd1;

  localparam logic [TICK_W-1:0] STATIC_DELAY_RST = 8'd10;
  localparam logic [6:0]        BLINK_HALF_RST   = 7'd20;

  typedef enum logic [2:0] {
    FN_WRITE_RAW    = 3'd0,
    FN_WRITE_SCALED = 3'd1,
    FN_OFF          = 3'd2,
    FN_SET_MODE     = 3'd3,
    FN_TICK         = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    MODE_STATIC = 3'd0,
    MODE_BLINK  = 3'd1,
    MODE_ROLL   = 3'd2,
    MODE_BREATH = 3'd3,
    MODE_OFF    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_LATCH = 2'd1,
    KIND_OFF   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FX_PLAIN  = 2'd0,
    FX_ROLL   = 2'd1,
    FX_BREATH = 2'd2
  } fx_e;

  typedef enum logic [3:0] {
    DP_NOP          = 4'd0,
    DP_WRITE_RAW    = 4'd1,
    DP_WRITE_SCALED = 4'd2,
    DP_CLEAR        = 4'd3,
    DP_BLANK        = 4'd4,
    DP_PREP         = 4'd5,
    DP_WEIGHT       = 4'd6,
    DP_PIXEL        = 4'd7,
    DP_LATCH        = 4'd8
  } dp_op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_WEIGHT = 2'd1,
    ST_SEND   = 2'd2,
    ST_LATCH  = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e              op;
    fx_e                 fx;
    logic [TICK_W-1:0]   tick;
  } dp_cmd_t;

  typedef struct packed {
    logic last_pixel;
  } dp_status_t;

  // floor(c / 10) for an 8-bit value: exact through c * 205 >> 11.
  function automatic logic [CHAN_W-1:0] div10(input logic [CHAN_W-1:0] c);
    logic [18:0] prod;
    prod = 19'(c) * 19'd205;
    return prod[18:11];
  endfunction

  // Raised-cosine weight, round(256 * sin^2(pi * p / 128)) for p in 0..64.
  function automatic logic [WEIGHT_W-1:0] sin_sq(input logic [6:0] p);
    logic [WEIGHT_W-1:0] w;
    case (p)
      7'd0:  w = 9'd0;   7'd1:  w = 9'd0;   7'd2:  w = 9'd1;   7'd3:  w = 9'd1;
      7'd4:  w = 9'd2;   7'd5:  w = 9'd4;   7'd6:  w = 9'd6;   7'd7:  w = 9'd7;
      7'd8:  w = 9'd10;  7'd9:  w = 9'd12;  7'd10: w = 9'd15;  7'd11: w = 9'd18;
      7'd12: w = 9'd22;  7'd13: w = 9'd25;  7'd14: w = 9'd29;  7'd15: w = 9'd33;
      7'd16: w = 9'd37;  7'd17: w = 9'd42;  7'd18: w = 9'd47;  7'd19: w = 9'd52;
      7'd20: w = 9'd57;  7'd21: w = 9'd62;  7'd22: w = 9'd68;  7'd23: w = 9'd73;
      7'd24: w = 9'd79;  7'd25: w = 9'd85;  7'd26: w = 9'd91;  7'd27: w = 9'd97;
      7'd28: w = 9'd103; 7'd29: w = 9'd109; 7'd30: w = 9'd115; 7'd31: w = 9'd122;
      7'd32: w = 9'd128; 7'd33: w = 9'd134; 7'd34: w = 9'd141; 7'd35: w = 9'd147;
      7'd36: w = 9'd153; 7'd37: w = 9'd159; 7'd38: w = 9'd165; 7'd39: w = 9'd171;
      7'd40: w = 9'd177; 7'd41: w = 9'd183; 7'd42: w = 9'd188; 7'd43: w = 9'd194;
      7'd44: w = 9'd199; 7'd45: w = 9'd204; 7'd46: w = 9'd209; 7'd47: w = 9'd214;
      7'd48: w = 9'd219; 7'd49: w = 9'd223; 7'd50: w = 9'd227; 7'd51: w = 9'd231;
      7'd52: w = 9'd234; 7'd53: w = 9'd238; 7'd54: w = 9'd241; 7'd55: w = 9'd244;
      7'd56: w = 9'd246; 7'd57: w = 9'd249; 7'd58: w = 9'd250; 7'd59: w = 9'd252;
      7'd60: w = 9'd254; 7'd61: w = 9'd255; 7'd62: w = 9'd255; 7'd63: w = 9'd256;
      7'd64: w = 9'd256;
      default: w = 9'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/rlee_ctrl.sv */
module rlee_ctrl import rlee_pkg::*; #(
  parameter int unsigned ROW_LENGTH      = 6,
  parameter int unsigned ROLL_STEP_TICKS = 5,
  parameter int unsigned BREATH_PERIOD   = 200,
  parameter int unsigned LED_COUNT       = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           func_i,
  input  logic [3:0]           led_i,
  input  logic [1:0]           mode_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output dp_cmd_t              cmd_o,
  input  dp_status_t           status_i
);

  localparam logic [9:0] ROLL_WRAP = 10'(ROW_LENGTH * ROLL_STEP_TICKS);
  localparam logic [8:0] BR_LIMIT  = 9'(BREATH_PERIOD);
  localparam logic [5:0] LED_MAX   = 6'(LED_COUNT);

  ctrl_state_e       state_q, state_d;
  mode_e             mode_q, mode_d;
  fx_e               fx_q, fx_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [TICK_W-1:0] delay_q;
  logic [6:0]        half_q;
  logic [TICK_W-1:0] tick_eff;
  logic              led_ok;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign led_ok      = ({2'b00, led_i} >= 6'd1) && ({2'b00, led_i} <= LED_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_STATIC;
      fx_q    <= FX_PLAIN;
      tick_q  <= '0;
      delay_q <= STATIC_DELAY_RST;
      half_q  <= BLINK_HALF_RST;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      fx_q    <= fx_d;
      tick_q  <= tick_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_STATIC_DELAY: delay_q <= cfg_data_i;
          CFG_BLINK_HALF:   half_q  <= cfg_data_i[6:0];
          default:          ;
        endcase
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    fx_d        = fx_q;
    tick_d      = tick_q;
    tick_eff    = tick_q;
    cmd_o.op    = DP_NOP;
    cmd_o.fx    = fx_q;
    cmd_o.tick  = tick_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (func_e'(func_i))
            FN_WRITE_RAW: begin
              if (led_ok) begin
                cmd_o.op = DP_WRITE_RAW;
              end
            end
            FN_WRITE_SCALED: begin
              if (led_ok) begin
                cmd_o.op = DP_WRITE_SCALED;
                mode_d   = MODE_STATIC;
                tick_d   = '0;
              end
            end
            FN_OFF: begin
              cmd_o.op = DP_CLEAR;
              mode_d   = MODE_OFF;
              tick_d   = '0;
            end
            FN_SET_MODE: begin
              mode_d = mode_e'({1'b0, mode_i});
              tick_d = '0;
            end
            FN_TICK: begin
              unique case (mode_q)
                MODE_STATIC: begin
                  if (tick_q >= delay_q) begin
                    tick_d     = '0;
                    fx_d       = FX_PLAIN;
                    cmd_o.op   = DP_PREP;
                    cmd_o.fx   = FX_PLAIN;
                    state_d    = ST_WEIGHT;
                  end else begin
                    tick_d = tick_q + 8'd1;
                  end
                end
                MODE_BLINK: begin
                  if (tick_q == 8'd1) begin
                    fx_d     = FX_PLAIN;
                    cmd_o.op = DP_PREP;
                    cmd_o.fx = FX_PLAIN;
                    state_d  = ST_WEIGHT;
                  end else if (tick_q == {1'b0, half_q}) begin
                    cmd_o.op = DP_BLANK;
                  end else if (tick_q >= {half_q, 1'b0}) begin
                    tick_eff = '0;
                  end
                  tick_d = tick_eff + 8'd1;
                end
                MODE_ROLL: begin
                  if ({2'b00, tick_q} >= ROLL_WRAP) begin
                    tick_eff = '0;
                  end
                  tick_d     = tick_eff + 8'd1;
                  fx_d       = FX_ROLL;
                  cmd_o.op   = DP_PREP;
                  cmd_o.fx   = FX_ROLL;
                  cmd_o.tick = tick_eff;
                  state_d    = ST_WEIGHT;
                end
                MODE_BREATH: begin
                  if ({1'b0, tick_q} > BR_LIMIT) begin
                    tick_d = '0;
                  end else begin
                    tick_d = tick_q + 8'd1;
                  end
                  fx_d     = FX_BREATH;
                  cmd_o.op = DP_PREP;
                  cmd_o.fx = FX_BREATH;
                  state_d  = ST_WEIGHT;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_WEIGHT: begin
        cmd_o.op = DP_WEIGHT;
        state_d  = ST_SEND;
      end
      ST_SEND: begin
        cmd_o.op = DP_PIXEL;
        if (status_i.last_pixel) begin
          state_d = ST_LATCH;
        end
      end
      ST_LATCH: begin
        cmd_o.op = DP_LATCH;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // The tick counter must not move while a frame is being sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && $past(state_q) != ST_IDLE) |-> $stable(tick_q))
    else $error("tick counter changed during a frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start && func_i == FN_WRITE_SCALED && led_ok)
      |=> (mode_q == MODE_STATIC && tick_q == '0))
    else $error("scaled write did not select static mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start && func_i == FN_TICK && mode_q == MODE_OFF)
      |=> (state_q == ST_IDLE && tick_q == $past(tick_q)))
    else $error("tick in off mode started a frame");

endmodule

/* rtl/rlee_datapath.sv */
module rlee_datapath import rlee_pkg::*; #(
  parameter int unsigned ROW_LENGTH      = 6,
  parameter int unsigned ROLL_STEP_TICKS = 5,
  parameter int unsigned BREATH_PERIOD   = 200,
  parameter int unsigned LED_COUNT       = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic [3:0]        led_i,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  output logic              strobe,
  output logic [1:0]        kind_o,
  output logic [3:0]        led_number_o,
  output logic [CHAN_W-1:0] red_out_o,
  output logic [CHAN_W-1:0] green_out_o,
  output logic [CHAN_W-1:0] blue_out_o,
  output logic              last_o
);

  localparam int unsigned IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned SW        = $clog2(ROW_LENGTH);
  localparam int unsigned AW        = ((IDX_W > SW) ? IDX_W : SW) + 1;
  localparam int unsigned FULL_LEDS = (LED_COUNT / ROW_LENGTH) * ROW_LENGTH;
  localparam int unsigned PROD_W    = 29;

  // Reciprocals for tick / ROLL_STEP_TICKS and tick * 128 / BREATH_PERIOD, both
  // exact for an 8-bit tick with a 16-bit shift.
  localparam logic [20:0] ROLL_MUL = 21'((2**16 + ROLL_STEP_TICKS - 1) / ROLL_STEP_TICKS);
  localparam logic [20:0] BR_MUL   = 21'((2**23 + BREATH_PERIOD - 1) / BREATH_PERIOD);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [SW-1:0]    POS_MAX  = SW'(ROW_LENGTH - 1);
  localparam logic [AW-1:0]    RL_A     = AW'(ROW_LENGTH);
  localparam logic [AW-1:0]    FULL_A   = AW'(FULL_LEDS);

  logic [3*CHAN_W-1:0] frame_q [LED_COUNT];
  logic [PROD_W-1:0]   prod_q;
  logic [SW-1:0]       s_q;
  logic [WEIGHT_W-1:0] w_q;
  logic [IDX_W-1:0]    j_q;
  logic [SW-1:0]       pos_q;
  logic [AW-1:0]       base_q;

  logic                strobe_q;
  kind_e               kind_q;
  logic [3:0]          led_q;
  logic [CHAN_W-1:0]   red_q, green_q, blue_q;
  logic                last_q;

  logic [20:0]         mul_op;
  logic [PROD_W-1:0]   prod_d;
  logic [6:0]          q;
  logic [7:0]          q_mirror;
  logic [6:0]          p;
  logic [AW-1:0]       rot_t, rot_r, src_wide;
  logic [IDX_W-1:0]    src_idx;
  logic [5:0]          led_m1;
  logic [IDX_W-1:0]    wr_idx;
  logic [5:0]          led_num_w;
  logic [3*CHAN_W-1:0] pix;
  logic [16:0]         r_prod, g_prod, b_prod;
  logic [3*CHAN_W-1:0] wr_data;

  always_comb begin
    mul_op = (cmd_i.fx == FX_ROLL) ? ROLL_MUL : BR_MUL;
    prod_d = PROD_W'(cmd_i.tick) * PROD_W'(mul_op);

    q        = prod_q[22:16];
    q_mirror = 8'd128 - {1'b0, q};
    p        = (q <= 7'd64) ? q : q_mirror[6:0];

    // Inside a full row, output position pos shows the LED (pos - s - 1) mod row length.
    rot_t    = AW'(pos_q) + AW'(ROW_LENGTH - 1) - AW'(s_q);
    rot_r    = (rot_t >= RL_A) ? (rot_t - RL_A) : rot_t;
    src_wide = base_q + rot_r;
    if (cmd_i.fx == FX_ROLL && AW'(j_q) < FULL_A) begin
      src_idx = src_wide[IDX_W-1:0];
    end else begin
      src_idx = j_q;
    end

    pix    = frame_q[src_idx];
    r_prod = 17'(pix[23:16]) * 17'(w_q);
    g_prod = 17'(pix[15:8])  * 17'(w_q);
    b_prod = 17'(pix[7:0])   * 17'(w_q);

    led_m1    = {2'b00, led_i} - 6'd1;
    wr_idx    = led_m1[IDX_W-1:0];
    led_num_w = 6'(j_q) + 6'd1;

    if (cmd_i.op == DP_WRITE_SCALED) begin
      wr_data = {div10(red_i), div10(green_i), div10(blue_i)};
    end else begin
      wr_data = {red_i, green_i, blue_i};
    end
  end

  assign status_o.last_pixel = (j_q == LAST_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        frame_q[i] <= '0;
      end
    end else begin
      unique case (cmd_i.op)
        DP_WRITE_RAW, DP_WRITE_SCALED: frame_q[wr_idx] <= wr_data;
        DP_CLEAR: begin
          for (int i = 0; i < LED_COUNT; i++) begin
            frame_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      j_q      <= '0;
      pos_q    <= '0;
      base_q   <= '0;
    end else begin
      strobe_q <= 1'b0;
      unique case (cmd_i.op)
        DP_WRITE_RAW, DP_WRITE_SCALED, DP_CLEAR, DP_BLANK, DP_PIXEL, DP_LATCH:
          strobe_q <= 1'b1;
        DP_WEIGHT: begin
          j_q    <= '0;
          pos_q  <= '0;
          base_q <= '0;
        end
        default: ;
      endcase
      if (cmd_i.op == DP_PIXEL) begin
        j_q <= j_q + IDX_W'(1);
        if (pos_q == POS_MAX) begin
          pos_q  <= '0;
          base_q <= base_q + RL_A;
        end else begin
          pos_q <= pos_q + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_PREP: prod_q <= prod_d;
      DP_WEIGHT: begin
        s_q <= prod_q[16 +: SW];
        w_q <= (cmd_i.fx == FX_BREATH) ? sin_sq(p) : WEIGHT_W'(256);
      end
      DP_WRITE_RAW, DP_WRITE_SCALED: begin
        kind_q  <= KIND_PIXEL;
        led_q   <= led_i;
        red_q   <= wr_data[23:16];
        green_q <= wr_data[15:8];
        blue_q  <= wr_data[7:0];
        last_q  <= 1'b1;
      end
      DP_CLEAR, DP_BLANK: begin
        kind_q  <= KIND_OFF;
        led_q   <= '0;
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
        last_q  <= 1'b1;
      end
      DP_PIXEL: begin
        kind_q  <= KIND_PIXEL;
        led_q   <= led_num_w[3:0];
        red_q   <= r_prod[15:8];
        green_q <= g_prod[15:8];
        blue_q  <= b_prod[15:8];
        last_q  <= 1'b0;
      end
      DP_LATCH: begin
        kind_q  <= KIND_LATCH;
        led_q   <= '0;
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
        last_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign strobe       = strobe_q;
  assign kind_o       = kind_q;
  assign led_number_o = led_q;
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign last_o       = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_LATCH) |=> (strobe_q && last_q && kind_q == KIND_LATCH))
    else $error("latch transfer not closing the frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_PIXEL) |-> (j_q <= LAST_IDX))
    else $error("pixel index beyond the frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_MAX)
    else $error("row position beyond the row length");

endmodule

/* rtl/rgb_led_effect_engine_unit.sv */
// Channel   Direction  Handshake                Payload
// command   in         start / busy             func_i, led_i, red_i, green_i, blue_i, mode_i
// result    out        strobe (one cycle)       kind_o, led_number_o, red_out_o, green_out_o,
//                                               blue_out_o, last_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Only a tick that sends a frame raises busy. A write with a valid LED number, an off
// command or a blink tick that switches the LEDs off sends one result, in the cycle after
// the transfer; set mode and the other ticks that send no frame send nothing. A tick that
// sends a frame keeps busy high through the weight state, the send state for each pixel in
// turn and the latch state, as the pixels share the single frame read port.
// Reset clears the frame, selects static mode and loads the register defaults.
// Results cannot be held off by the receiver; each is valid for exactly one cycle.
module rgb_led_effect_engine_unit import rlee_pkg::*; #(
  parameter int unsigned ROW_LENGTH      = 6,
  parameter int unsigned ROLL_STEP_TICKS = 5,
  parameter int unsigned BREATH_PERIOD   = 200,
  parameter int unsigned LED_COUNT       = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           func_i,
  input  logic [3:0]           led_i,
  input  logic [CHAN_W-1:0]    red_i,
  input  logic [CHAN_W-1:0]    green_i,
  input  logic [CHAN_W-1:0]    blue_i,
  input  logic [1:0]           mode_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 strobe,
  output logic [1:0]           kind_o,
  output logic [3:0]           led_number_o,
  output logic [CHAN_W-1:0]    red_out_o,
  output logic [CHAN_W-1:0]    green_out_o,
  output logic [CHAN_W-1:0]    blue_out_o,
  output logic                 last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rlee_ctrl #(
    .ROW_LENGTH      (ROW_LENGTH),
    .ROLL_STEP_TICKS (ROLL_STEP_TICKS),
    .BREATH_PERIOD   (BREATH_PERIOD),
    .LED_COUNT       (LED_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .led_i       (led_i),
    .mode_i      (mode_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  rlee_datapath #(
    .ROW_LENGTH      (ROW_LENGTH),
    .ROLL_STEP_TICKS (ROLL_STEP_TICKS),
    .BREATH_PERIOD   (BREATH_PERIOD),
    .LED_COUNT       (LED_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .led_i        (led_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .strobe       (strobe),
    .kind_o       (kind_o),
    .led_number_o (led_number_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .last_o       (last_o)
  );

endmodule
